>>> rtl/pdb_pkg.sv
// Shared types, codes and arithmetic helpers for the Porter-Duff blender.
`default_nettype none

package pdb_pkg;

   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;
   localparam int NUM_CH  = 4;
   localparam int PROD_W  = 2 * CHAN_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_STREAM    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID_COLOR   = 2'd2;

   typedef enum logic [3:0] {
      MODE_CLEAR    = 4'd0,
      MODE_SRC      = 4'd1,
      MODE_DST      = 4'd2,
      MODE_SRC_OVER = 4'd3,
      MODE_DST_OVER = 4'd4,
      MODE_SRC_IN   = 4'd5,
      MODE_DST_IN   = 4'd6,
      MODE_SRC_OUT  = 4'd7,
      MODE_DST_OUT  = 4'd8,
      MODE_SRC_ATOP = 4'd9,
      MODE_DST_ATOP = 4'd10,
      MODE_XOR      = 4'd11
   } mode_type;

   // result = sat(fa * pa / 255 + fb * pb / 255), per channel
   typedef struct packed {
      logic [CHAN_W-1:0]  fa;
      logic [PIXEL_W-1:0] pa;
      logic [CHAN_W-1:0]  fb;
      logic [PIXEL_W-1:0] pb;
      logic               last;
   } term_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] a;
      logic [PIXEL_W-1:0] b;
      logic               last;
   } scaled_type;

   // (x * 65793 + 2^23) >> 24, with 65793 = 2^16 + 2^8 + 1
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [32:0] acc;
      acc = {1'b0, x, 16'd0} + {9'd0, x, 8'd0} + {17'd0, x} + 33'h0_0080_0000;
      return acc[31:24];
   endfunction

endpackage

`default_nettype wire

>>> rtl/pdb_factor.sv
// Stage 1: source select and mode decode into two weighted terms.
`default_nettype none

module pdb_factor import pdb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [3:0]         blend_mode,
   input  wire logic               use_stream_source,
   input  wire logic [PIXEL_W-1:0] solid_color,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [PIXEL_W-1:0] src_pixel,
   input  wire logic [PIXEL_W-1:0] dst_pixel,
   input  wire logic               last_in_row,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output term_type                out_term
);

   logic               valid_ff, valid_in;
   term_type           term_ff, term_in;
   logic [PIXEL_W-1:0] s;
   logic [CHAN_W-1:0]  sa, da;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      s  = use_stream_source ? src_pixel : solid_color;
      sa = s[31:24];
      da = dst_pixel[31:24];
      term_in.fa   = '0;
      term_in.pa   = s;
      term_in.fb   = '0;
      term_in.pb   = dst_pixel;
      term_in.last = last_in_row;
      case (mode_type'(blend_mode))
         MODE_SRC:      term_in.fa = CHAN_MAX;
         MODE_DST:      term_in.fb = CHAN_MAX;
         MODE_SRC_OVER: begin
            term_in.fa = CHAN_MAX;
            term_in.fb = CHAN_MAX - sa;
         end
         MODE_DST_OVER: begin
            term_in.fa = CHAN_MAX - da;
            term_in.fb = CHAN_MAX;
         end
         MODE_SRC_IN:   term_in.fa = da;
         MODE_DST_IN:   term_in.fb = sa;
         MODE_SRC_OUT:  term_in.fa = CHAN_MAX - da;
         MODE_DST_OUT:  term_in.fb = CHAN_MAX - sa;
         MODE_SRC_ATOP: begin
            term_in.fa = da;
            term_in.fb = CHAN_MAX - sa;
         end
         MODE_DST_ATOP: begin
            term_in.fa = CHAN_MAX - da;
            term_in.fb = sa;
         end
         MODE_XOR:      begin
            term_in.fa = CHAN_MAX - da;
            term_in.fb = CHAN_MAX - sa;
         end
         default: begin
            term_in.fa = '0;
            term_in.fb = '0;
         end
      endcase
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         term_ff <= term_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_term  = term_ff;

endmodule

`default_nettype wire

>>> rtl/pdb_scale.sv
// Stages 2 and 3: channel products, then rounding divide by 255.
`default_nettype none

module pdb_scale import pdb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire term_type in_term,
   output logic      out_valid,
   input  wire logic out_ready,
   output scaled_type out_scaled
);

   logic              prod_valid_ff, prod_valid_in;
   logic              quot_valid_ff, quot_valid_in;
   logic              prod_ready;
   logic [PROD_W-1:0] prod_a_ff [NUM_CH];
   logic [PROD_W-1:0] prod_b_ff [NUM_CH];
   logic [PROD_W-1:0] prod_a_in [NUM_CH];
   logic [PROD_W-1:0] prod_b_in [NUM_CH];
   logic              prod_last_ff;
   scaled_type        quot_ff, quot_in;

   assign prod_ready = !quot_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         prod_a_in[k] = PROD_W'(in_term.fa) * PROD_W'(in_term.pa[k*CHAN_W +: CHAN_W]);
         prod_b_in[k] = PROD_W'(in_term.fb) * PROD_W'(in_term.pb[k*CHAN_W +: CHAN_W]);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         quot_in.a[k*CHAN_W +: CHAN_W] = div255(prod_a_ff[k]);
         quot_in.b[k*CHAN_W +: CHAN_W] = div255(prod_b_ff[k]);
      end
      quot_in.last = prod_last_ff;
   end

   assign prod_valid_in = in_ready   ? in_valid      : prod_valid_ff;
   assign quot_valid_in = prod_ready ? prod_valid_ff : quot_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         quot_valid_ff <= quot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_a_ff    <= prod_a_in;
         prod_b_ff    <= prod_b_in;
         prod_last_ff <= in_term.last;
      end
      if (prod_ready && prod_valid_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid  = quot_valid_ff;
   assign out_scaled = quot_ff;

endmodule

`default_nettype wire

>>> rtl/porter_duff_blend.sv
// Top level of the Porter-Duff blender: registers, pipeline and saturating sum.
`default_nettype none

// Blends one premultiplied ARGB8888 source pixel (stream or solid color) into
// a destination pixel under the twelve Porter-Duff modes; codes 12 to 15 give
// clear. Four register stages (decode, multiply, divide by 255, saturating
// add) lie between the input transfer and the result transfer, and one pixel
// is accepted every cycle while the result side keeps up. Write the
// configuration registers only while no pixel is in flight.

module porter_duff_blend import pdb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [63:0]          req_tdata,   // src_pixel, dst_pixel
   input  wire logic                 req_tlast,   // last_in_row
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,   // result_pixel
   output logic                      rsp_tlast,   // row_done
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   logic [3:0]         blend_mode_ff, blend_mode_in;
   logic               use_stream_ff, use_stream_in;
   logic [PIXEL_W-1:0] solid_color_ff, solid_color_in;

   logic       term_valid, term_ready;
   term_type   term;
   logic       scaled_valid, scaled_ready;
   scaled_type scaled;

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic               out_last_ff;

   always_comb begin
      blend_mode_in  = blend_mode_ff;
      use_stream_in  = use_stream_ff;
      solid_color_in = solid_color_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BLEND_MODE:  blend_mode_in  = csr_wdata[3:0];
            CSR_USE_STREAM:  use_stream_in  = csr_wdata[0];
            CSR_SOLID_COLOR: solid_color_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff  <= '0;
         use_stream_ff  <= 1'b0;
         solid_color_ff <= '0;
      end else begin
         blend_mode_ff  <= blend_mode_in;
         use_stream_ff  <= use_stream_in;
         solid_color_ff <= solid_color_in;
      end
   end

   pdb_factor u_factor (
      .clock             (clock),
      .reset             (reset),
      .blend_mode        (blend_mode_ff),
      .use_stream_source (use_stream_ff),
      .solid_color       (solid_color_ff),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .src_pixel         (req_tdata[31:0]),
      .dst_pixel         (req_tdata[63:32]),
      .last_in_row       (req_tlast),
      .out_valid         (term_valid),
      .out_ready         (term_ready),
      .out_term          (term)
   );

   pdb_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (term_valid),
      .in_ready   (term_ready),
      .in_term    (term),
      .out_valid  (scaled_valid),
      .out_ready  (scaled_ready),
      .out_scaled (scaled)
   );

   assign scaled_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      logic [CHAN_W:0] sum;
      for (int k = 0; k < NUM_CH; k++) begin
         sum = {1'b0, scaled.a[k*CHAN_W +: CHAN_W]} + {1'b0, scaled.b[k*CHAN_W +: CHAN_W]};
         out_pixel_in[k*CHAN_W +: CHAN_W] = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
      end
   end

   assign out_valid_in = scaled_ready ? scaled_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scaled_ready && scaled_valid) begin
         out_pixel_ff <= out_pixel_in;
         out_last_ff  <= scaled.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

>>> sim/pdb_blend_check_pkg.sv
// Scoreboard for the Porter-Duff blender: register mirror, blend predictor and result check.
`timescale 1ns / 1ps

package pdb_blend_check_pkg;
   import pdb_pkg::*;

   typedef struct {
      logic [31:0] pixel;
      logic        row_done;
   } blended_pixel_type;

   class pixel_blend_checker_type;
      logic [3:0]        mode_reg;
      logic              use_stream_reg;
      logic [31:0]       solid_reg;
      blended_pixel_type expected_pixels[$];
      int                mismatches;
      int                pixels_checked;

      function new();
         mode_reg       = MODE_CLEAR;
         use_stream_reg = 1'b0;
         solid_reg      = '0;
         mismatches     = 0;
         pixels_checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_BLEND_MODE:  mode_reg = value[3:0];
            CSR_USE_STREAM:  use_stream_reg = value[0];
            CSR_SOLID_COLOR: solid_reg = value;
            default: ;
         endcase
      endfunction

      // channel * factor / 255, rounded the way the datapath does it
      function logic [7:0] scale_chan(logic [7:0] factor, logic [7:0] c);
         longint unsigned prod;
         prod = (longint'(factor) * longint'(c)) * 65793 + (longint'(1) << 23);
         return prod[31:24];
      endfunction

      function logic [31:0] scale_pixel(logic [7:0] factor, logic [31:0] p);
         logic [31:0] r;
         for (int k = 0; k < 4; k++) r[8*k +: 8] = scale_chan(factor, p[8*k +: 8]);
         return r;
      endfunction

      function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
         logic [31:0] r;
         logic [8:0]  sum;
         for (int k = 0; k < 4; k++) begin
            sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            r[8*k +: 8] = sum[8] ? 8'hFF : sum[7:0];
         end
         return r;
      endfunction

      function logic [31:0] blend_pixel(logic [31:0] s, logic [31:0] d);
         logic [7:0] sa;
         logic [7:0] da;
         sa = s[31:24];
         da = d[31:24];
         case (mode_reg)
            MODE_SRC:      return s;
            MODE_DST:      return d;
            MODE_SRC_OVER: return sat_add(s, scale_pixel(8'hFF - sa, d));
            MODE_DST_OVER: return sat_add(d, scale_pixel(8'hFF - da, s));
            MODE_SRC_IN:   return scale_pixel(da, s);
            MODE_DST_IN:   return scale_pixel(sa, d);
            MODE_SRC_OUT:  return scale_pixel(8'hFF - da, s);
            MODE_DST_OUT:  return scale_pixel(8'hFF - sa, d);
            MODE_SRC_ATOP: return sat_add(scale_pixel(8'hFF - sa, d), scale_pixel(da, s));
            MODE_DST_ATOP: return sat_add(scale_pixel(8'hFF - da, s), scale_pixel(sa, d));
            MODE_XOR:
               return sat_add(scale_pixel(8'hFF - sa, d), scale_pixel(8'hFF - da, s));
            default:       return '0;
         endcase
      endfunction

      function void note_pixel(logic [31:0] src, logic [31:0] dst, logic last);
         blended_pixel_type e;
         e.pixel    = blend_pixel(use_stream_reg ? src : solid_reg, dst);
         e.row_done = last;
         expected_pixels.push_back(e);
      endfunction

      function void check_pixel(logic [31:0] pixel, logic row_done);
         blended_pixel_type e;
         if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer: result_pixel %h row_done %b", pixel, row_done);
            mismatches++;
            return;
         end
         e = expected_pixels.pop_front();
         pixels_checked++;
         if (pixel !== e.pixel) begin
            $error("result_pixel: expected %h, actual %h", e.pixel, pixel);
            mismatches++;
         end
         if (row_done !== e.row_done) begin
            $error("row_done: expected %b, actual %b", e.row_done, row_done);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

endpackage

>>> sim/tb_porter_duff_blend.sv
// Testbench top for the Porter-Duff blender: stimulus, flow control and watchdog.
`timescale 1ns / 1ps

module tb_porter_duff_blend;
   import pdb_pkg::*;
   import pdb_blend_check_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SEGMENTS       = 5;
   localparam int SEGMENT_PIXELS = 90;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [63:0]          req_tdata;   // src_pixel, dst_pixel
   logic                 req_tlast;   // last_in_row
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;   // result_pixel
   logic                 rsp_tlast;   // row_done
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int idle_cycles   = 0;

   pixel_blend_checker_type scoreboard = new();

   porter_duff_blend i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check each transfer, stall at random
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            scoreboard.check_pixel(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] rand_pixel();
      logic [7:0]  a;
      logic [31:0] p;
      case ($urandom_range(9))
         0: p = $urandom();
         1: p = 32'h0000_0000;
         2: p = 32'hFFFF_FFFF;
         default: begin
            a = 8'($urandom_range(255));
            p = {a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a))};
         end
      endcase
      return p;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      scoreboard.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dst, src};
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      scoreboard.note_pixel(src, dst, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every mode code, non-premultiplied inputs that saturate
      csr_write(CSR_USE_STREAM, 32'd1);
      for (int m = 0; m < 16; m++) begin
         csr_write(CSR_BLEND_MODE, 32'(m));
         if (m % 2 == 1)
            send_pixel(32'h80FF_7F40, 32'h40C0_FF20, 1'b1);
         else
            send_pixel(32'hC060_30FF, 32'hFF80_4020, 1'b0);
         wait_drained();
      end
      csr_write(CSR_BLEND_MODE, MODE_SRC_OVER);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
      wait_drained();
      // solid color source, stream source ignored
      csr_write(CSR_USE_STREAM, 32'd0);
      csr_write(CSR_SOLID_COLOR, 32'hFFFF_FFFF);
      csr_write(CSR_BLEND_MODE, MODE_XOR);
      send_pixel(32'h0000_0000, 32'h8080_8080, 1'b1);
      wait_drained();
      csr_write(CSR_BLEND_MODE, MODE_DST);
      send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
      wait_drained();
      csr_write(CSR_SOLID_COLOR, 32'h0000_0000);
      csr_write(CSR_BLEND_MODE, MODE_SRC_ATOP);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      wait_drained();

      // random: three flow-control profiles, several register settings each
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin req_idle_pct = 9;  rsp_stall_pct = 56; end
            1: begin req_idle_pct = 56; rsp_stall_pct = 9;  end
            default: begin req_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int s = 0; s < SEGMENTS; s++) begin
            wait_drained();
            if ($urandom_range(99) < 10)
               csr_write(CSR_BLEND_MODE, $urandom_range(15, 12));
            else
               csr_write(CSR_BLEND_MODE, $urandom_range(11));
            csr_write(CSR_USE_STREAM, $urandom_range(1));
            csr_write(CSR_SOLID_COLOR, rand_pixel());
            for (int i = 0; i < SEGMENT_PIXELS; i++) begin
               send_pixel(rand_pixel(), rand_pixel(), $urandom_range(7) == 0);
               // hold off until the pipeline has emptied, config unchanged
               if (p == 0 && s == 0 && i == SEGMENT_PIXELS / 2)
                  wait_drained();
            end
         end
      end

      wait_drained();
      if (scoreboard.pending() != 0) begin
         $error("%0d expected results never arrived", scoreboard.pending());
         scoreboard.mismatches++;
      end
      $display("Checked %0d blended pixels: all sixteen mode codes, stream and solid sources,",
               scoreboard.pixels_checked);
      $display("saturating sums, and sender/receiver stalls in three flow-control profiles.");
      if (scoreboard.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> porter_duff_blend.f
rtl/pdb_pkg.sv
rtl/pdb_factor.sv
rtl/pdb_scale.sv
rtl/porter_duff_blend.sv
sim/pdb_blend_check_pkg.sv
sim/tb_porter_duff_blend.sv
